@@ rtl/core/akl_toussaint_hull_prefilter_defines.svh @@
// Assertion macros for the hull prefilter RTL.
// No dependencies; taken in by akth_back, the module that carries checks.
`ifndef AKL_TOUSSAINT_HULL_PREFILTER_DEFINES_SVH
`define AKL_TOUSSAINT_HULL_PREFILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AKTH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("akth: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define AKTH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("akth: next-cycle check failed");

`endif

@@ rtl/core/akth_pkg.sv @@
// Shared types and constants for the hull prefilter.
// No dependencies; imported by every module of the block.
package akth_pkg;

    localparam int COORD_BITS_DEF = 16;

    typedef enum logic [1:0] {
        OP_SCAN   = 2'd0,
        OP_FILTER = 2'd1,
        OP_EMIT   = 2'd2
    } t_op;

    // Head of the command queue as seen by the back end.
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_cmd;

endpackage

@@ rtl/core/akl_toussaint_hull_prefilter.sv @@
// Two-pass convex-hull prefilter: scan, filter against the extreme quadrilateral, emit.
// Path: front queue, then the s1, s2 and output registers; an emit yields four results.
// Throughput: one item per cycle unless the output stalls; emit holds the queue head.
// Reset: synchronous active-low i_rst_n clears extremes, queue and pipeline valids.
// Depends on akth_pkg, akth_front and akth_back.
module akl_toussaint_hull_prefilter #(
    parameter int COORD_BITS = akth_pkg::COORD_BITS_DEF,
    localparam int DATA_W    = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,  // point_x, point_y, zero pad
    input  logic [1:0]        s_axis_tuser,  // op
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,  // out_x, out_y, zero pad
    output logic              m_axis_tuser,  // keep
    output logic              m_axis_tlast   // last
);
    import akth_pkg::*;

    t_cmd                         cmd;
    logic signed [COORD_BITS-1:0] q_x, q_y;
    logic signed [COORD_BITS-1:0] res_x, res_y;
    logic                         pop;

    // Front: take every transfer, drop unused op codes, hold up to two commands.
    akth_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_x     (s_axis_tdata[COORD_BITS-1:0]),
        .i_y     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .o_cmd   (cmd),
        .o_x     (q_x),
        .o_y     (q_y),
        .i_pop   (pop)
    );

    // Back: update extremes on scan, run the four side tests on filter,
    // step through the extremes on emit; stall as one when the output is held.
    akth_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_x     (q_x),
        .i_y     (q_y),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_x     (res_x),
        .o_y     (res_y),
        .o_keep  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

    // Pack the result, zero padding above the coordinates.
    assign m_axis_tdata = DATA_W'({res_y, res_x});

endmodule

@@ rtl/core/akth_front.sv @@
// Front end: accepts stream items, drops unused op codes, queues the rest.
// Depends on akth_pkg.
module akth_front #(
    parameter int COORD_BITS = akth_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_op,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    output akth_pkg::t_cmd               o_cmd,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    input  logic                         i_pop
);
    import akth_pkg::*;

    logic [1:0]                   r_count;
    logic [1:0]                   n_count;
    t_op                          r_q0_op, r_q1_op;
    logic signed [COORD_BITS-1:0] r_q0_x, r_q0_y, r_q1_x, r_q1_y;
    logic                         op_ok;
    logic                         push;

    // Classify: op code 3 is taken and dropped.
    always_comb begin
        unique case (i_op)
            OP_SCAN, OP_FILTER, OP_EMIT: op_ok = 1'b1;
            default:                     op_ok = 1'b0;
        endcase
    end

    assign o_ready = (r_count != 2'd2);
    assign push    = i_valid && o_ready && op_ok;

    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // Two-entry queue; slot 0 is always the head.
    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_q0_op <= r_q1_op;
            r_q0_x  <= r_q1_x;
            r_q0_y  <= r_q1_y;
        end
        if (push) begin
            if ((r_count == 2'd0) || (i_pop && r_count == 2'd1)) begin
                r_q0_op <= t_op'(i_op);
                r_q0_x  <= i_x;
                r_q0_y  <= i_y;
            end else begin
                r_q1_op <= t_op'(i_op);
                r_q1_x  <= i_x;
                r_q1_y  <= i_y;
            end
        end
    end

    assign o_cmd.valid = (r_count != 2'd0);
    assign o_cmd.op    = r_q0_op;
    assign o_x         = r_q0_x;
    assign o_y         = r_q0_y;

endmodule

@@ rtl/core/akth_back.sv @@
// Back end: extreme tracking, emit sequencing, side tests and output register.
// Depends on akth_pkg and the assertion macro header.
`include "akl_toussaint_hull_prefilter_defines.svh"

module akth_back #(
    parameter int COORD_BITS = akth_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  akth_pkg::t_cmd               i_cmd,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output logic                         o_keep,
    output logic                         o_last
);
    import akth_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam logic [1:0] EMIT_LAST = 2'd3;

    // Extremes: left, right, bottom, top.
    logic signed [COORD_BITS-1:0] r_lx, r_ly, r_rx, r_ry, r_bx, r_by, r_tx, r_ty;
    logic signed [COORD_BITS-1:0] n_lx, n_ly, n_rx, n_ry, n_bx, n_by, n_tx, n_ty;
    logic                         r_seeded, n_seeded;
    logic [1:0]                   r_emit_cnt, n_emit_cnt;

    logic advance, exec, exec_scan, exec_emit;

    // Edge endpoints a -> b for edges L-T, T-R, R-B, B-L.
    logic signed [COORD_BITS-1:0] ax [4];
    logic signed [COORD_BITS-1:0] ay [4];
    logic signed [COORD_BITS-1:0] bx [4];
    logic signed [COORD_BITS-1:0] by [4];

    logic                         r_s1_valid, r_s1_test, r_s1_keep, r_s1_last;
    logic signed [COORD_BITS-1:0] r_s1_x, r_s1_y, n_s1_x, n_s1_y;
    logic signed [DW-1:0]         r_s1_da [4];
    logic signed [DW-1:0]         r_s1_db [4];
    logic signed [DW-1:0]         r_s1_dc [4];
    logic signed [DW-1:0]         r_s1_dd [4];

    logic                         r_s2_valid, r_s2_test, r_s2_keep, r_s2_last;
    logic signed [COORD_BITS-1:0] r_s2_x, r_s2_y;
    logic signed [PW-1:0]         r_s2_p1 [4];
    logic signed [PW-1:0]         r_s2_p2 [4];

    logic [SW-1:0]                sum [4];
    logic [3:0]                   outside;

    logic                         r_out_valid, r_out_keep, r_out_last;
    logic signed [COORD_BITS-1:0] r_out_x, r_out_y;

    assign advance   = !r_out_valid || i_ready;
    assign exec      = i_cmd.valid && advance;
    assign exec_scan = exec && (i_cmd.op == OP_SCAN);
    assign exec_emit = exec && (i_cmd.op == OP_EMIT);
    assign o_pop     = exec && (!exec_emit || r_emit_cnt == EMIT_LAST);

    // Extreme update and emit sequencing.
    always_comb begin
        n_lx = r_lx; n_ly = r_ly; n_rx = r_rx; n_ry = r_ry;
        n_bx = r_bx; n_by = r_by; n_tx = r_tx; n_ty = r_ty;
        n_seeded   = r_seeded;
        n_emit_cnt = r_emit_cnt;
        if (exec_scan) begin
            n_seeded = 1'b1;
            if (!r_seeded) begin
                n_lx = i_x; n_ly = i_y; n_rx = i_x; n_ry = i_y;
                n_bx = i_x; n_by = i_y; n_tx = i_x; n_ty = i_y;
            end else begin
                if (i_x < r_lx) begin
                    n_lx = i_x; n_ly = i_y;
                end
                if (i_x > r_rx) begin
                    n_rx = i_x; n_ry = i_y;
                end
                if (i_y < r_by) begin
                    n_bx = i_x; n_by = i_y;
                end
                if (i_y > r_ty) begin
                    n_tx = i_x; n_ty = i_y;
                end
            end
        end
        if (exec_emit) begin
            n_emit_cnt = r_emit_cnt + 2'd1;
            if (r_emit_cnt == EMIT_LAST) begin
                // Clear after the fourth extreme leaves.
                n_lx = '0; n_ly = '0; n_rx = '0; n_ry = '0;
                n_bx = '0; n_by = '0; n_tx = '0; n_ty = '0;
                n_seeded = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lx <= '0; r_ly <= '0; r_rx <= '0; r_ry <= '0;
            r_bx <= '0; r_by <= '0; r_tx <= '0; r_ty <= '0;
            r_seeded   <= 1'b0;
            r_emit_cnt <= 2'd0;
        end else begin
            r_lx <= n_lx; r_ly <= n_ly; r_rx <= n_rx; r_ry <= n_ry;
            r_bx <= n_bx; r_by <= n_by; r_tx <= n_tx; r_ty <= n_ty;
            r_seeded   <= n_seeded;
            r_emit_cnt <= n_emit_cnt;
        end
    end

    always_comb begin
        ax[0] = r_lx; ay[0] = r_ly; bx[0] = r_tx; by[0] = r_ty;
        ax[1] = r_tx; ay[1] = r_ty; bx[1] = r_rx; by[1] = r_ry;
        ax[2] = r_rx; ay[2] = r_ry; bx[2] = r_bx; by[2] = r_by;
        ax[3] = r_bx; ay[3] = r_by; bx[3] = r_lx; by[3] = r_ly;
    end

    // Stage 1 payload: the point for a filter, the selected extreme for an emit.
    always_comb begin
        n_s1_x = i_x;
        n_s1_y = i_y;
        if (i_cmd.op == OP_EMIT) begin
            unique case (r_emit_cnt)
                2'd0:    begin n_s1_x = r_lx; n_s1_y = r_ly; end
                2'd1:    begin n_s1_x = r_rx; n_s1_y = r_ry; end
                2'd2:    begin n_s1_x = r_bx; n_s1_y = r_by; end
                default: begin n_s1_x = r_tx; n_s1_y = r_ty; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= exec && !exec_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_x    <= n_s1_x;
            r_s1_y    <= n_s1_y;
            r_s1_test <= (i_cmd.op == OP_FILTER) && r_seeded;
            // Unseeded filter keeps the point; an emit keeps iff seeded.
            r_s1_keep <= (i_cmd.op == OP_FILTER) ? !r_seeded : r_seeded;
            r_s1_last <= (i_cmd.op == OP_FILTER) || (r_emit_cnt == EMIT_LAST);
            for (int e = 0; e < 4; e++) begin
                r_s1_da[e] <= {by[e][COORD_BITS-1], by[e]} - {ay[e][COORD_BITS-1], ay[e]};
                r_s1_db[e] <= {i_x[COORD_BITS-1], i_x} - {ax[e][COORD_BITS-1], ax[e]};
                r_s1_dc[e] <= {ax[e][COORD_BITS-1], ax[e]} - {bx[e][COORD_BITS-1], bx[e]};
                r_s1_dd[e] <= {i_y[COORD_BITS-1], i_y} - {ay[e][COORD_BITS-1], ay[e]};
            end
        end
    end

    // Stage 2: eight exact products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            r_s2_test <= r_s1_test;
            r_s2_keep <= r_s1_keep;
            r_s2_last <= r_s1_last;
            for (int e = 0; e < 4; e++) begin
                r_s2_p1[e] <= r_s1_da[e] * r_s1_db[e];
                r_s2_p2[e] <= r_s1_dc[e] * r_s1_dd[e];
            end
        end
    end

    // Stage 3: side sign per edge, strictly negative means outside.
    always_comb begin
        for (int e = 0; e < 4; e++) begin
            sum[e] = {r_s2_p1[e][PW-1], r_s2_p1[e]} + {r_s2_p2[e][PW-1], r_s2_p2[e]};
            outside[e] = sum[e][SW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_x    <= r_s2_x;
            r_out_y    <= r_s2_y;
            r_out_keep <= r_s2_test ? (|outside) : r_s2_keep;
            r_out_last <= r_s2_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_x     = r_out_x;
    assign o_y     = r_out_y;
    assign o_keep  = r_out_keep;
    assign o_last  = r_out_last;

    `AKTH_ASSERT_IMP(a_emit_holds_head, i_clk, i_rst_n, r_emit_cnt != 2'd0, i_cmd.valid && i_cmd.op == OP_EMIT)
    `AKTH_ASSERT_NXT(a_scan_seeds, i_clk, i_rst_n, exec_scan, r_seeded)
    `AKTH_ASSERT_NXT(a_emit_clears, i_clk, i_rst_n, exec_emit && r_emit_cnt == EMIT_LAST, !r_seeded && r_emit_cnt == 2'd0)
    `AKTH_ASSERT_IMP(a_test_is_filter, i_clk, i_rst_n, r_s1_valid && r_s1_test, r_s1_last && !r_s1_keep)

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for akl_toussaint_hull_prefilter: a directed table, then random scan,
// filter and emit runs, each result transfer checked in order against an in-bench hull model.
// Depends on akth_pkg and the prefilter RTL only.
module tb;
    import akth_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int DW = ((2 * CW + 7) / 8) * 8;
    localparam logic [1:0] OP_RESERVED = 2'd3;   // unused code, the block must ignore it
    localparam int MAX_SHOWN = 10;
    localparam int N_TABLE   = 23;
    localparam int HOLD_OFF  = 400;               // long receiver stall, in cycles

    typedef logic signed [CW-1:0] t_coord;

    localparam t_coord COORD_MIN = {1'b1, {(CW - 1){1'b0}}};
    localparam t_coord COORD_MAX = {1'b0, {(CW - 1){1'b1}}};

    // One result transfer as seen on the master side.
    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   keep;
        logic   last;
    } t_hull_out;

    // One row of the directed table; when typed is set the want_* fields give the result
    // directly (every result of the row carries them, last on the final one).
    typedef struct packed {
        logic [1:0] op;
        t_coord     x;
        t_coord     y;
        logic       typed;
        t_coord     want_x;
        t_coord     want_y;
        logic       want_keep;
    } t_table_row;

    logic          i_clk;
    logic          i_rst_n       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata  = '0;   // point_x, point_y, zero pad
    logic [1:0]    s_axis_tuser  = '0;   // op
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;         // out_x, out_y, zero pad
    logic          m_axis_tuser;         // keep
    logic          m_axis_tlast;         // last

    akl_toussaint_hull_prefilter #(
        .COORD_BITS(CW)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Hull model: the four extremes, the seeded flag and the results still owed
    // ------------------------------------------------------------------
    t_coord    lft_x = '0, lft_y = '0, rgt_x = '0, rgt_y = '0;
    t_coord    bot_x = '0, bot_y = '0, top_x = '0, top_y = '0;
    bit        have_point = 1'b0;
    t_hull_out step_res [4];
    t_hull_out owed_q [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int mismatches    = 0;
    int points_sent   = 0;

    // Append one expected result at the tail of the owed queue.
    function automatic void owe_result(input t_hull_out r);
        owed_q.insert(owed_q.size(), r);
    endfunction

    // Strictly outside the directed side a->b: the cross product is negative.
    // Coordinates are 16 bits, so a 64-bit product and sum are exact.
    function automatic bit beyond_side(input t_coord ax, input t_coord ay, input t_coord bx,
                                       input t_coord by, input t_coord px, input t_coord py);
        longint lhs, rhs;
        lhs = (longint'(by) - longint'(ay)) * (longint'(px) - longint'(ax));
        rhs = (longint'(ax) - longint'(bx)) * (longint'(py) - longint'(ay));
        return (lhs + rhs) < 0;
    endfunction

    // Advance the hull model by one accepted item; return how many results it owes.
    function automatic int hull_step(input logic [1:0] op, input t_coord px, input t_coord py);
        bit keep;
        case (op)
            OP_SCAN: begin
                if (!have_point) begin
                    // first point seeds all four extremes
                    lft_x = px; lft_y = py; rgt_x = px; rgt_y = py;
                    bot_x = px; bot_y = py; top_x = px; top_y = py;
                    have_point = 1'b1;
                end else begin
                    // strict compares: on a tie the earlier point stays
                    if (px < lft_x) begin lft_x = px; lft_y = py; end
                    if (px > rgt_x) begin rgt_x = px; rgt_y = py; end
                    if (py < bot_y) begin bot_x = px; bot_y = py; end
                    if (py > top_y) begin top_x = px; top_y = py; end
                end
                return 0;
            end
            OP_FILTER: begin
                // no quadrilateral yet: keep everything; a point on a side counts as inside
                keep = !have_point
                    || beyond_side(lft_x, lft_y, top_x, top_y, px, py)
                    || beyond_side(top_x, top_y, rgt_x, rgt_y, px, py)
                    || beyond_side(rgt_x, rgt_y, bot_x, bot_y, px, py)
                    || beyond_side(bot_x, bot_y, lft_x, lft_y, px, py);
                step_res[0] = '{px, py, keep, 1'b1};
                return 1;
            end
            OP_EMIT: begin
                keep = have_point;
                step_res[0] = '{lft_x, lft_y, keep, 1'b0};
                step_res[1] = '{rgt_x, rgt_y, keep, 1'b0};
                step_res[2] = '{bot_x, bot_y, keep, 1'b0};
                step_res[3] = '{top_x, top_y, keep, 1'b1};
                lft_x = '0; lft_y = '0; rgt_x = '0; rgt_y = '0;
                bot_x = '0; bot_y = '0; top_x = '0; top_y = '0;
                have_point = 1'b0;
                return 4;
            end
            default: return 0;
        endcase
    endfunction

    function automatic void flag_result(input string why, input t_hull_out want,
                                        input t_hull_out got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("%0t: %s: want x=%0d y=%0d keep=%0b last=%0b, got x=%0d y=%0d keep=%0b last=%0b",
                     $realtime, why, want.x, want.y, want.keep, want.last,
                     got.x, got.y, got.keep, got.last);
    endfunction

    // ------------------------------------------------------------------
    // Result side: check every transfer, then choose tready for the next edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_sink
        t_hull_out got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.x    = t_coord'(m_axis_tdata[CW-1:0]);
            got.y    = t_coord'(m_axis_tdata[2*CW-1:CW]);
            got.keep = m_axis_tuser;
            got.last = m_axis_tlast;
            if (owed_q.size() == 0) begin
                flag_result("result with nothing owed", '0, got);
            end else begin
                want = owed_q.pop_front();
                if (got.x !== want.x || got.y !== want.y
                    || got.keep !== want.keep || got.last !== want.last)
                    flag_result("result mismatch", want, got);
            end
        end
        // a pending hold-off wins over the random stalls
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------

    // Offer one item, with random gaps first; return at the edge that takes the transfer.
    task automatic offer_item(input logic [1:0] op, input t_coord px, input t_coord py);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            // drop valid and put junk on the data lines while idle
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= DW'($urandom);
            s_axis_tuser  <= 2'($urandom_range(3));
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DW'({py, px});
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        if (op != OP_RESERVED)
            points_sent++;
    endtask

    task automatic send_point(input logic [1:0] op, input t_coord px, input t_coord py);
        int n;
        offer_item(op, px, py);
        n = hull_step(op, px, py);
        for (int k = 0; k < n; k++)
            owe_result(step_res[k]);
    endtask

    // Hold the input idle until every owed result has come back.
    task automatic drain_results();
        int guard;
        s_axis_tvalid <= 1'b0;
        for (guard = 0; guard < 50000 && owed_q.size() != 0; guard++)
            @(posedge i_clk);
    endtask

    // Mostly small and medium coordinates so that points fall inside and outside alike,
    // with a quarter of values full-range and the odd exact extreme, zero or minus one.
    function automatic t_coord pick_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) begin
            case ($urandom_range(3))
                0: return COORD_MIN;
                1: return COORD_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        if (sel < 50)
            return t_coord'(int'($urandom_range(100)) - 50);
        if (sel < 75)
            return t_coord'(int'($urandom_range(6000)) - 3000);
        return t_coord'($urandom);
    endfunction

    // A well-formed run is scans, then filters, then an emit; a few stray or broken ones.
    task automatic random_session();
        int pick, n_scan, n_filt;
        pick = $urandom_range(99);
        if (pick < 10) begin
            // stray item of any code, unused one included
            send_point(2'($urandom_range(3)), pick_coord(), pick_coord());
            return;
        end
        n_scan = $urandom_range(1, 8);
        for (int i = 0; i < n_scan; i++)
            send_point(OP_SCAN, pick_coord(), pick_coord());
        n_filt = $urandom_range(1, 10);
        for (int i = 0; i < n_filt; i++) begin
            if ($urandom_range(99) < 5)
                send_point(OP_RESERVED, pick_coord(), pick_coord());
            send_point(OP_FILTER, pick_coord(), pick_coord());
        end
        // now and then skip the emit so the next run scans on top of stale extremes
        if ($urandom_range(99) < 90)
            send_point(OP_EMIT, pick_coord(), pick_coord());
    endtask

    t_table_row directed_rows [N_TABLE] = '{
        // filter before any scan keeps the point; emit before any scan gives zeros
        '{OP_FILTER,   COORD_MAX,   COORD_MIN,   1'b1, COORD_MAX, COORD_MIN, 1'b1},
        '{OP_EMIT,     16'sd0,      16'sd0,      1'b1, 16'sd0,    16'sd0,    1'b0},
        // one point seeds all four extremes; the unused code leaves them alone
        '{OP_SCAN,     COORD_MIN,   COORD_MAX,   1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_RESERVED, 16'sd5,      -16'sd5,     1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_EMIT,     16'sd0,      16'sd0,      1'b1, COORD_MIN, COORD_MAX, 1'b1},
        // emit clears the state
        '{OP_EMIT,     16'sd0,      16'sd0,      1'b1, 16'sd0,    16'sd0,    1'b0},
        // full-range diamond, with ties that must not replace the first extreme
        '{OP_SCAN,     16'sd0,      16'sd0,      1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_SCAN,     COORD_MIN,   16'sd0,      1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_SCAN,     COORD_MAX,   16'sd0,      1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_SCAN,     16'sd0,      COORD_MIN,   1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_SCAN,     16'sd0,      COORD_MAX,   1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_SCAN,     COORD_MIN,   16'sd100,    1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_SCAN,     16'sd200,    COORD_MAX,   1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_RESERVED, COORD_MIN,   COORD_MIN,   1'b0, 16'sd0,    16'sd0,    1'b0},
        // centre, a vertex, corners well outside, a point near a side
        '{OP_FILTER,   16'sd0,      16'sd0,      1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_FILTER,   COORD_MIN,   16'sd0,      1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_FILTER,   COORD_MAX,   COORD_MAX,   1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_FILTER,   COORD_MIN,   COORD_MIN,   1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_FILTER,   16'sd16384,  -16'sd16384, 1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_EMIT,     16'sd0,      16'sd0,      1'b0, 16'sd0,    16'sd0,    1'b0},
        // after the clear a filter is kept again
        '{OP_FILTER,   -16'sd1,     -16'sd1,     1'b1, -16'sd1,   -16'sd1,   1'b1},
        '{OP_SCAN,     -16'sd5,     16'sd3,      1'b0, 16'sd0,    16'sd0,    1'b0},
        '{OP_EMIT,     16'sd0,      16'sd0,      1'b1, -16'sd5,   16'sd3,    1'b1}
    };

    initial begin : stimulus
        int n;
        t_table_row row;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles 37 in 100, receiver 46 in 100
        send_idle_pct = 37;
        recv_idle_pct = 46;

        // walk the directed table; typed rows override the model's results
        for (int r = 0; r < N_TABLE; r++) begin
            row = directed_rows[r];
            offer_item(row.op, row.x, row.y);
            n = hull_step(row.op, row.x, row.y);
            for (int k = 0; k < n; k++) begin
                if (row.typed)
                    owe_result(t_hull_out'{row.want_x, row.want_y, row.want_keep,
                                           k == n - 1});
                else
                    owe_result(step_res[k]);
            end
        end

        while (points_sent < 150)
            random_session();

        // pause the sender until every owed result is in
        drain_results();

        // swap the idle rates
        send_idle_pct = 46;
        recv_idle_pct = 37;
        while (points_sent < 280)
            random_session();

        // no idling; open with a long receiver stall so the block fills and holds its input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = HOLD_OFF;
        while (points_sent < 410)
            random_session();

        drain_results();
        repeat (16) @(posedge i_clk);

        if (owed_q.size() != 0) begin
            $display("%0d results never arrived", owed_q.size());
            mismatches += owed_q.size();
        end
        if (mismatches == 0)
            $display("PASS akl_toussaint_hull_prefilter");
        else
            $display("FAIL akl_toussaint_hull_prefilter");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin : watchdog
        #1_000_000;
        $display("FAIL akl_toussaint_hull_prefilter");
        $finish;
    end

endmodule
